### src/dss_pkg.sv
// Shared types, constants and status codes for the descending sorted set.
package dss_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COUNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } ctl_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } flag_t;

endpackage

### src/dss_cell.sv
// One slot of the sorted row: holds a value, compares it and shifts with its neighbours.
module dss_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  dss_pkg::ctl_t                     ctl,
  input  logic signed [dss_pkg::DATA_W-1:0] key,
  input  logic                              occ,
  input  logic                              left_gt,
  input  logic signed [dss_pkg::DATA_W-1:0] left_entry,
  input  logic signed [dss_pkg::DATA_W-1:0] right_entry,
  output logic signed [dss_pkg::DATA_W-1:0] entry,
  output dss_pkg::flag_t                    flag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= '0;
    end else if (ctl.cmp) begin
      flag.gt <= occ && (entry > key);
      flag.eq <= occ && (entry == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !flag.gt) begin
      entry <= left_gt ? key : left_entry;
    end else if (ctl.rem && !flag.gt) begin
      entry <= right_entry;
    end
  end

endmodule

### src/descending_sorted_set.sv
// Top level of the descending sorted set: a row of compare-and-shift cells with a count.
//
//   channel  ports                 handshake
//   command  cmd (op, value)       taken when start is high and busy is low
//   result   result (status,count) shown for one cycle while done is high
//
// An item has a compare step, in which every cell compares its value with the key, and
// an update step, in which the row shifts and the count is updated. A new item may be
// taken in the cycle in which the previous one updates the row. The result appears in
// the cycle after the update and cannot be held off. Reset empties the set at once.
module descending_sorted_set #(
  parameter int CAPACITY = dss_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dss_pkg::in_t  cmd,
  output logic          done,
  output dss_pkg::out_t result
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic signed [dss_pkg::DATA_W-1:0] key;
  logic                              op;
  logic                              pend;
  logic [OCC_W-1:0]                  occupancy;
  logic [OCC_W-1:0]                  occupancy_next;

  logic signed [dss_pkg::DATA_W-1:0] entries [CAPACITY];
  dss_pkg::flag_t                    flags   [CAPACITY];
  logic [CAPACITY-1:0]               eq_vec;
  logic [CAPACITY-1:0]               gt_vec;
  logic [CAPACITY-1:0]               occ_vec;

  logic          found;
  logic          full;
  dss_pkg::ctl_t ctl;
  logic [2:0]    status;

  assign found = |eq_vec;
  assign full  = (occupancy == OCC_W'(CAPACITY));

  assign ctl.cmp = busy;
  assign ctl.ins = pend && (op == dss_pkg::OP_INSERT) && !found && !full;
  assign ctl.rem = pend && (op == dss_pkg::OP_REMOVE) && found;

  always_comb begin
    occupancy_next = occupancy;
    if (ctl.ins) begin
      occupancy_next = occupancy + 1'b1;
    end else if (ctl.rem) begin
      occupancy_next = occupancy - 1'b1;
    end
  end

  always_comb begin
    priority if (found) begin
      status = (op == dss_pkg::OP_INSERT) ? dss_pkg::ST_DUPLICATE : dss_pkg::ST_REMOVED;
    end else if (op == dss_pkg::OP_REMOVE) begin
      status = dss_pkg::ST_NOT_FOUND;
    end else if (full) begin
      status = dss_pkg::ST_FULL;
    end else begin
      status = dss_pkg::ST_INSERTED;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                              left_gt;
      logic signed [dss_pkg::DATA_W-1:0] left_entry;
      logic signed [dss_pkg::DATA_W-1:0] right_entry;

      assign occ_vec[i] = (OCC_W'(i) < occupancy);
      assign eq_vec[i]  = flags[i].eq;
      assign gt_vec[i]  = flags[i].gt;

      if (i == 0) begin : g_first
        assign left_gt    = 1'b1;
        assign left_entry = key;
      end else begin : g_mid
        assign left_gt    = gt_vec[i-1];
        assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = entries[i+1];
      end

      dss_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .key         (key),
        .occ         (occ_vec[i]),
        .left_gt     (left_gt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entries[i]),
        .flag        (flags[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      done      <= 1'b0;
      occupancy <= '0;
    end else begin
      done <= pend;
      pend <= busy;
      if (start && !busy) begin
        busy <= 1'b1;
      end else begin
        busy <= 1'b0;
      end
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key <= cmd.value;
      op  <= cmd.op;
    end
    if (pend) begin
      result.status <= status;
      result.count  <= dss_pkg::COUNT_W'(occupancy_next);
    end
  end

  a_distinct : assert property (@(posedge clk) disable iff (rst) $onehot0(eq_vec))
    else $error("More than one cell matches the key.");

  a_bound : assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(CAPACITY))
    else $error("Occupancy exceeds capacity.");

  a_ins_count : assert property (@(posedge clk) disable iff (rst)
    done && (result.status == dss_pkg::ST_INSERTED) |-> occupancy == $past(occupancy) + 1'b1)
    else $error("Insert did not raise the count by one.");

  a_one_cmp : assert property (@(posedge clk) disable iff (rst) busy |=> !busy && pend)
    else $error("Compare phase did not hand over to update.");

endmodule

### bench/descending_sorted_set_tb.sv
// Self-checking bench for the descending sorted set: queued command items, prediction, result check.
module descending_sorted_set_tb;

  localparam int CAP        = dss_pkg::CAPACITY_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam int POOL_SIZE  = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dss_pkg::in_t  cmd = '0;
  logic done;
  dss_pkg::out_t result;

  dss_pkg::in_t  pending_items [$];
  dss_pkg::out_t expected_results [$];

  logic signed [dss_pkg::DATA_W-1:0] held_vals [CAP];
  int   held_count = 0;
  logic signed [dss_pkg::DATA_W-1:0] pool [POOL_SIZE];

  int   accepted = 0;
  int   launched = 0;
  int   fails = 0;
  int   quiet = 0;
  bit   steady = 1'b0;

  descending_sorted_set #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic dss_pkg::out_t apply_item(dss_pkg::in_t item);
    dss_pkg::out_t r;
    int hit;
    int pos;
    logic signed [dss_pkg::DATA_W-1:0] v;
    v = $signed(item.value);
    hit = -1;
    r = '0;
    for (int i = 0; i < held_count; i++)
      if (held_vals[i] == v) hit = i;
    if (item.op == dss_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        r.status = dss_pkg::ST_DUPLICATE;
      end else if (held_count >= CAP) begin
        r.status = dss_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_vals[pos] > v) pos++;
        for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = v;
        held_count++;
        r.status = dss_pkg::ST_INSERTED;
      end
    end else begin
      if (hit < 0) begin
        r.status = dss_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
        held_count--;
        r.status = dss_pkg::ST_REMOVED;
      end
    end
    r.count = dss_pkg::COUNT_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_results.push_back(apply_item(cmd));
      accepted++;
    end
  end

  always @(posedge clk) begin
    dss_pkg::out_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d count %0d",
                 $time, result.status, result.count);
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, result.status);
          fails++;
        end
        if (result.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d",
                   $time, want.count, result.count);
          fails++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted == launched) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 37)) begin
        cmd <= pending_items.pop_front();
        start <= 1'b1;
        launched++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_item(logic op, logic signed [dss_pkg::DATA_W-1:0] value);
    dss_pkg::in_t item;
    item.op = op;
    item.value = value;
    pending_items.push_back(item);
  endtask

  task automatic random_items(int n);
    int fill_bias;
    logic op;
    logic signed [dss_pkg::DATA_W-1:0] value;
    fill_bias = 70;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) fill_bias = (fill_bias == 70) ? 30 : 70;
      if ($urandom_range(0, 99) < 8) begin
        op = 1'(($urandom_range(0, 1)));
        value = $urandom;
      end else begin
        op = ($urandom_range(0, 99) < fill_bias) ? dss_pkg::OP_INSERT : dss_pkg::OP_REMOVE;
        value = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
      end
      push_item(op, value);
    end
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (!(pending_items.size() == 0 && !start && expected_results.size() == 0));
  endtask

  initial begin
    pool[0] = 32'sh7FFFFFFF;
    pool[1] = 32'sh80000000;
    pool[2] = 32'sh00000000;
    pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++)
      pool[i] = (i % 2) ? $signed($urandom_range(0, 40)) - 20 : $signed($urandom);

    push_item(dss_pkg::OP_REMOVE, 32'sd5);
    push_item(dss_pkg::OP_INSERT, 32'sh7FFFFFFF);
    push_item(dss_pkg::OP_INSERT, 32'sh80000000);
    push_item(dss_pkg::OP_INSERT, 32'sh00000000);
    push_item(dss_pkg::OP_INSERT, -32'sd1);
    push_item(dss_pkg::OP_INSERT, 32'sh00000000);
    for (int i = 1; i <= 12; i++)
      push_item(dss_pkg::OP_INSERT, (i % 2) ? i * 1000 : -i * 1000);
    push_item(dss_pkg::OP_INSERT, 32'sd77);
    push_item(dss_pkg::OP_INSERT, -32'sd1);
    push_item(dss_pkg::OP_REMOVE, 32'sh80000000);
    push_item(dss_pkg::OP_REMOVE, 32'sh7FFFFFFF);
    push_item(dss_pkg::OP_REMOVE, 32'sd77);
    push_item(dss_pkg::OP_REMOVE, 32'sd5000);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    settle();
    random_items(450);
    settle();
    steady = 1'b1;
    random_items(200);
    settle();
    steady = 1'b0;
    random_items(426);
    settle();

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### descending_sorted_set.f
src/dss_pkg.sv
src/dss_cell.sv
src/descending_sorted_set.sv
bench/descending_sorted_set_tb.sv
